// ===== rtl/mndd_pkg.sv =====
// ============================================================================
// mndd_pkg
// Shared types, constants and code-parsing helpers of the nibble delta decoder.
// ============================================================================
package mndd_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int NCH_W        = 7;
    localparam int PTS_W        = 24;
    localparam int SCNT_W       = 30;
    localparam int WORD_W       = 16;
    localparam int PEND_W       = 12;
    localparam int BUF_W        = WORD_W + PEND_W;
    localparam int BCNT_W       = 5;
    localparam int PCNT_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_BYTES    = 2'd2;

    // code lengths in bits
    localparam logic [BCNT_W-1:0] LEN_SHORT = 5'd4;
    localparam logic [BCNT_W-1:0] LEN_MID   = 5'd8;
    localparam logic [BCNT_W-1:0] LEN_LONG  = 5'd12;
    localparam logic [BCNT_W-1:0] LEN_ABS   = 5'd16;

    // bit buffer operations
    typedef struct packed {
        logic load;
        logic consume;
        logic park;
        logic clear;
    } t_buf_ctl;

    // code at the head of the bit buffer
    typedef struct packed {
        logic              avail;
        logic              absolute;
        logic [WORD_W-1:0] value;
    } t_code_info;

    // history lookup request
    typedef struct packed {
        logic [CH_W-1:0]   addr;
        logic              absolute;
        logic [WORD_W-1:0] delta;
    } t_lookup;

    function automatic logic [BCNT_W-1:0] code_len(input logic [3:0] code);
        logic [BCNT_W-1:0] len;
        if (!code[3]) begin
            len = LEN_SHORT;
        end else if (!code[2]) begin
            len = LEN_MID;
        end else if (!code[1]) begin
            len = LEN_LONG;
        end else begin
            len = LEN_ABS;
        end
        return len;
    endfunction

    // delta or absolute value of the code in the top bits
    function automatic logic [WORD_W-1:0] code_value(input logic [BUF_W-1:0] bits);
        logic [3:0]        code;
        logic [WORD_W-1:0] v;
        code = bits[BUF_W-1 -: 4];
        if (!code[3]) begin
            v = {{13{code[2]}}, code[2:0]};
        end else if (!code[2]) begin
            v = {{10{code[1]}}, code[1:0], bits[BUF_W-5 -: 4]};
        end else if (!code[1]) begin
            v = {{7{code[0]}}, code[0], bits[BUF_W-5 -: 8]};
        end else begin
            v = {{4{bits[BUF_W-5]}}, bits[BUF_W-5 -: 12]};
        end
        return v;
    endfunction

endpackage

// ===== rtl/mndd_bitbuf.sv =====
// ============================================================================
// mndd_bitbuf
// Left-aligned bit buffer: merges leftover bits with a new word, parses the
// code at its head and shifts consumed codes out.
// ============================================================================
module mndd_bitbuf (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mndd_pkg::t_buf_ctl         i_ctl,
    input  logic [mndd_pkg::WORD_W-1:0] i_word,
    input  logic                       i_swap,
    output mndd_pkg::t_code_info       o_info
);
    import mndd_pkg::*;

    logic [BUF_W-1:0]  r_buf;
    logic [BCNT_W-1:0] r_cnt;
    logic [PEND_W-1:0] r_pend;
    logic [PCNT_W-1:0] r_pcnt;

    logic [WORD_W-1:0] w_word;
    logic [BCNT_W-1:0] w_len;
    logic [BCNT_W-1:0] w_excess;
    logic [BUF_W-1:0]  w_parked;
    logic [BUF_W-1:0]  w_merged;

    assign w_word   = i_swap ? {i_word[7:0], i_word[15:8]} : i_word;
    assign w_len    = code_len(r_buf[BUF_W-1 -: 4]);
    assign w_merged = {r_pend, {WORD_W{1'b0}}} | ({w_word, {PEND_W{1'b0}}} >> r_pcnt);
    // at most 15 bits are left over; keep the newest 12
    assign w_excess = r_cnt - 5'(PEND_W);
    assign w_parked = r_buf << w_excess[1:0];

    assign o_info.avail    = (r_cnt >= LEN_SHORT) && (r_cnt >= w_len);
    assign o_info.absolute = (w_len == LEN_ABS);
    assign o_info.value    = code_value(r_buf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= '0;
            r_pcnt <= '0;
        end else if (i_ctl.clear) begin
            r_cnt  <= '0;
            r_pend <= '0;
            r_pcnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= BCNT_W'(r_pcnt) + 5'(WORD_W);
        end else if (i_ctl.consume) begin
            r_cnt <= r_cnt - w_len;
        end else if (i_ctl.park) begin
            if (r_cnt > 5'(PEND_W)) begin
                r_pend <= w_parked[BUF_W-1 -: PEND_W];
                r_pcnt <= PCNT_W'(PEND_W);
            end else begin
                r_pend <= r_buf[BUF_W-1 -: PEND_W];
                r_pcnt <= r_cnt[PCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_buf <= w_merged;
        end else if (i_ctl.consume) begin
            r_buf <= r_buf << w_len;
        end
    end

endmodule

// ===== rtl/mndd_hist.sv =====
// ============================================================================
// mndd_hist
// Per-channel history memory with valid bits and the shared 16-bit adder.
// ============================================================================
module mndd_hist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_lookup,
    input  mndd_pkg::t_lookup           i_req,
    input  logic                        i_commit,
    output logic [mndd_pkg::WORD_W-1:0] o_result
);
    import mndd_pkg::*;

    logic [WORD_W-1:0]       r_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_vld;
    logic [WORD_W-1:0]       r_rd_data;
    logic                    r_hit;
    t_lookup                 r_req;
    logic [WORD_W-1:0]       w_hist;

    // an entry not written since the last clear reads as zero
    assign w_hist   = r_hit ? r_rd_data : '0;
    assign o_result = r_req.absolute ? r_req.delta : w_hist + r_req.delta;

    always_ff @(posedge i_clk) begin
        if (i_lookup) begin
            r_rd_data <= r_mem[i_req.addr];
            r_req     <= i_req;
        end
        if (i_commit) begin
            r_mem[r_req.addr] <= o_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_hit <= 1'b0;
        end else if (i_clear) begin
            r_vld <= '0;
            r_hit <= 1'b0;
        end else begin
            if (i_lookup) begin
                r_hit <= r_vld[i_req.addr];
            end
            if (i_commit) begin
                r_vld[r_req.addr] <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/multichannel_nibble_delta_decoder_core.sv =====
// ============================================================================
// multichannel_nibble_delta_decoder_core
// Variable-length nibble delta decoder for interleaved multichannel records.
// ============================================================================
// Usage:
//   Slave stream carries 16-bit words of the packed code stream, MSB first.
//   Master stream returns decoded samples in channel round-robin order; tuser
//   flags the last sample of a word, tlast flags the final sample of the
//   record. The cfg channel writes channel_count, points_per_channel and
//   swap_bytes; each such write restarts the record and clears the history.
//   Sequence: a word is taken in the idle state, then each sample passes
//   through a history lookup (decode state) and an add and write back
//   through the single adder (add state), and the last one returns straight
//   to idle; a word yields n samples (n = 1..4). The first sample enters
//   the output register from the add state. A word that arrives after the
//   record completes is taken and dropped in the idle state. The history
//   memory port and the shared adder set this sequence. No new word is taken
//   until the current one is fully decoded.
//   A stalled receiver holds the output register and freezes decoding.
//   Reset loads channel_count 1, points_per_channel 1, swap_bytes 0 and
//   clears history, leftover bits and counters. Once the record completes,
//   words are accepted and dropped until the next configuration write.
// ============================================================================
module multichannel_nibble_delta_decoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: word[15:0]
    input  logic [15:0]                        i_s_tdata,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: sample[15:0], channel[21:16], zero[23:22]
    output logic [23:0]                        o_m_tdata,
    // tuser: last_of_word[0]
    output logic                               o_m_tuser,
    output logic                               o_m_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mndd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mndd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mndd_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_ADD    = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [2:0]        r_n, n_n;
    logic [CH_W-1:0]   r_chan, n_chan;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [SCNT_W-1:0] r_count, n_count;
    logic              r_finished, n_finished;
    logic [SCNT_W-1:0] r_total;
    logic [NCH_W-1:0]  r_ch_count;
    logic [PTS_W-1:0]  r_points;
    logic              r_swap;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_sample;
    logic [CH_W-1:0]   r_out_ch;
    logic              r_out_low;
    logic              r_out_done;

    logic [NCH_W-1:0]  w_nch;
    logic [PTS_W-1:0]  w_pts;
    logic [30:0]       w_prod;
    logic              w_cfg_wr;
    logic              w_restart;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_emit;
    logic              w_done;
    logic              w_more;
    logic [CH_W-1:0]   w_cur_ch;
    logic [WORD_W-1:0] w_result;

    t_buf_ctl          w_ctl;
    t_code_info        w_info;
    t_lookup           w_req;
    logic              w_lookup;

    // effective configuration
    always_comb begin
        if (r_ch_count == '0) begin
            w_nch = NCH_W'(1);
        end else if (r_ch_count > NCH_W'(MAX_CHANNELS)) begin
            w_nch = NCH_W'(MAX_CHANNELS);
        end else begin
            w_nch = r_ch_count;
        end
        w_pts = (r_points == '0) ? PTS_W'(1) : r_points;
    end
    assign w_prod = {24'b0, w_nch} * {7'b0, w_pts};

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_restart   = w_cfg_wr && (i_cfg_index == REG_CHANNEL_COUNT
                         || i_cfg_index == REG_POINTS || i_cfg_index == REG_SWAP_BYTES);

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_cur_ch = ({1'b0, r_chan} >= w_nch) ? '0 : r_chan;
    assign w_done   = (r_count + SCNT_W'(1)) == r_total;
    // in the add state the buffer is already shifted past the current code
    assign w_more   = w_info.avail && (r_n != 3'd4);
    assign w_emit   = (r_state == S_ADD) && w_out_free;

    assign w_req.addr     = w_cur_ch;
    assign w_req.absolute = w_info.absolute;
    assign w_req.delta    = w_info.value;

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_chan     = r_chan;
        n_ch       = r_ch;
        n_count    = r_count;
        n_finished = r_finished;
        w_ctl      = '0;
        w_lookup   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && !r_finished) begin
                    w_ctl.load = 1'b1;
                    n_n        = '0;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (w_more) begin
                    w_ctl.consume = 1'b1;
                    w_lookup      = 1'b1;
                    n_ch          = w_cur_ch;
                    n_n           = r_n + 3'd1;
                    n_state       = S_ADD;
                end else begin
                    w_ctl.park = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ADD: begin
                if (w_out_free) begin
                    n_count = r_count + SCNT_W'(1);
                    n_chan  = ({1'b0, r_ch} + NCH_W'(1) >= w_nch) ? '0 : r_ch + CH_W'(1);
                    if (w_done) begin
                        n_finished  = 1'b1;
                        w_ctl.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else if (w_more) begin
                        n_state = S_DECODE;
                    end else begin
                        w_ctl.park = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_restart) begin
            w_ctl.clear = 1'b1;
        end
    end

    mndd_bitbuf u_bitbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_word  (i_s_tdata),
        .i_swap  (r_swap),
        .o_info  (w_info)
    );

    mndd_hist u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_restart),
        .i_lookup (w_lookup),
        .i_req    (w_req),
        .i_commit (w_emit),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_n        <= '0;
            r_chan     <= '0;
            r_ch       <= '0;
            r_count    <= '0;
            r_finished <= 1'b0;
            r_total    <= SCNT_W'(1);
            r_ch_count <= NCH_W'(1);
            r_points   <= PTS_W'(1);
            r_swap     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_n        <= n_n;
            r_ch       <= n_ch;
            r_total    <= w_prod[SCNT_W-1:0];
            if (w_restart) begin
                r_chan     <= '0;
                r_count    <= '0;
                r_finished <= 1'b0;
            end else begin
                r_chan     <= n_chan;
                r_count    <= n_count;
                r_finished <= n_finished;
            end
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    REG_CHANNEL_COUNT: r_ch_count <= i_cfg_data[NCH_W-1:0];
                    REG_POINTS:        r_points   <= i_cfg_data[PTS_W-1:0];
                    REG_SWAP_BYTES:    r_swap     <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_sample <= w_result;
            r_out_ch     <= r_ch;
            r_out_low    <= w_done || !w_more;
            r_out_done   <= w_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_ch, r_out_sample};
    assign o_m_tuser  = r_out_low;
    assign o_m_tlast  = r_out_done;

    a_finished_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_state == S_IDLE))
        else $error("record finished while decoding");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> (r_n != 3'd0 && r_n <= 3'd4))
        else $error("sample count per word out of range");

    a_decode_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECODE) |=> (r_state == S_ADD || r_state == S_IDLE))
        else $error("bad state after decode");

endmodule
